>>> design/tbmr_pkg.sv
package tbmr_pkg;

  // Default geometry of the screen and the largest triangle that is stored.
  localparam int unsigned SCREEN_WIDTH_DEF  = 608;
  localparam int unsigned SCREEN_HEIGHT_DEF = 684;
  localparam int unsigned MAX_GRID_DEF      = 32;

  // Fixed field widths and the grid size after reset.
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_RESET = 8;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned INDEX_W   = 10;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic wr_commit;
    logic index_en;
    logic read_en;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
  } sts_t;

endpackage

>>> design/tbmr_in_if.sv
interface tbmr_in_if;
  import tbmr_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [INDEX_W-1:0] block_index;
  logic               bit_value;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (
    output valid, operation, block_index, bit_value, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, operation, block_index, bit_value, pixel_x, pixel_y,
    output ready
  );

endinterface

>>> design/tbmr_out_if.sv
interface tbmr_out_if;

  logic valid;
  logic ready;
  logic pixel_on;

  modport source (
    output valid, pixel_on,
    input  ready
  );

  modport sink (
    input  valid, pixel_on,
    output ready
  );

endinterface

>>> design/triangular_block_mask_raster_top.sv
// Channel   Direction  Handshake         Payload
// req_i     in         valid / ready     operation, block_index, bit_value, pixel_x, pixel_y
// rsp_o     out        valid / ready     pixel_on
// cfg       in         cfg_we_i          cfg_data_i (grid size, 6 bits)
//
// A write item occupies the block for the capture and the commit. A query item occupies it for
// the capture, ten steps of the two restoring dividers that find the block column
// and row, a state in which the controller sees both dividers finish, the index
// multiply, the bit memory read and the load of the output register, which waits while an
// earlier result is still stalled there.
// After reset the bit memory is cleared one entry a cycle, all MAX_GRID*(MAX_GRID+1)/2
// entries (528 by default), with req_i.ready low; configuration writes are taken throughout.
// A result waiting in the output register does not stop the next input transfer.
module triangular_block_mask_raster_top import tbmr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_GRID      = MAX_GRID_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  tbmr_in_if.sink          req_i,
  tbmr_out_if.source       rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  logic pixel_on;

  // The controller sequences each item; it sees only the handshakes, the operation and the status.
  tbmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // The datapath holds the grid size registers, the dividers, the index logic and
  // the block bit memory.
  tbmr_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_GRID      (MAX_GRID)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .block_index_i (req_i.block_index),
    .bit_value_i   (req_i.bit_value),
    .pixel_x_i     (req_i.pixel_x),
    .pixel_y_i     (req_i.pixel_y),
    .pixel_on_o    (pixel_on)
  );

  assign req_i.ready    = in_ready;
  assign rsp_o.valid    = out_valid;
  assign rsp_o.pixel_on = pixel_on;

endmodule

>>> design/tbmr_div.sv
module tbmr_div #(
  parameter int unsigned NUM_W = 10,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_i};
    ge      = ~trial[DEN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign done_o = (cnt_q == '0);

endmodule

>>> design/tbmr_dp.sv
module tbmr_dp import tbmr_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_GRID      = MAX_GRID_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [INDEX_W-1:0] block_index_i,
  input  logic               bit_value_i,
  input  logic [COORD_W-1:0] pixel_x_i,
  input  logic [COORD_W-1:0] pixel_y_i,
  output logic               pixel_on_o
);

  localparam int unsigned StoreDepth = MAX_GRID * (MAX_GRID + 1) / 2;
  localparam int unsigned AW   = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned MW   = $clog2(MAX_GRID + 1);
  localparam int unsigned TW   = $clog2(StoreDepth + 1);
  localparam int unsigned CW   = (TW > INDEX_W) ? TW : INDEX_W;
  localparam int unsigned WW   = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned HW   = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned PW   = 2 * MW + 1;
  localparam int unsigned SW   = COORD_W + 1;
  localparam int unsigned MRst = (CFG_RESET > MAX_GRID) ? MAX_GRID : CFG_RESET;
  localparam int unsigned WRst = SCREEN_WIDTH / (MRst + 1);
  localparam int unsigned HRst = SCREEN_HEIGHT / (MRst + 1);
  localparam int unsigned TRst = MRst * (MRst + 1) / 2;

  // Block sizes and triangle sizes for every grid size, worked out at elaboration.
  logic [WW-1:0] wtab [0:MAX_GRID];
  logic [HW-1:0] htab [0:MAX_GRID];
  logic [TW-1:0] ttab [0:MAX_GRID];

  for (genvar g = 0; g <= MAX_GRID; g++) begin : g_tab
    localparam int unsigned WG = SCREEN_WIDTH / (g + 1);
    localparam int unsigned HG = SCREEN_HEIGHT / (g + 1);
    localparam int unsigned TG = g * (g + 1) / 2;
    assign wtab[g] = WW'(WG);
    assign htab[g] = HW'(HG);
    assign ttab[g] = TW'(TG);
  end

  logic [MW-1:0]      m_q, m_d;
  logic [WW-1:0]      width_q;
  logic [HW-1:0]      height_q;
  logic [TW-1:0]      total_q;
  logic [AW-1:0]      clr_q;
  logic [INDEX_W-1:0] wr_idx_q;
  logic               wr_bit_q;
  logic               wr_ok;
  logic [COORD_W-1:0] col, row;
  logic               done_x, done_y;
  logic [SW-1:0]      row_ext, sum, m_ext;
  logic               hit_d, hit_q;
  logic [MW-1:0]      r_s;
  logic [MW:0]        two_m1;
  logic [PW-1:0]      prod;
  logic [AW-1:0]      idx_d, idx_q;
  logic               bit_q;
  logic               pixel_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic               mem_wd;
  logic               bits_mem [0:StoreDepth-1];

  // Grid sizes above the stored maximum act as the maximum.
  always_comb begin
    if (int'(cfg_data_i) > MAX_GRID) begin
      m_d = MW'(MAX_GRID);
    end else begin
      m_d = MW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q      <= MW'(MRst);
      width_q  <= WW'(WRst);
      height_q <= HW'(HRst);
      total_q  <= TW'(TRst);
    end else if (cfg_we_i) begin
      m_q      <= m_d;
      width_q  <= wtab[m_d];
      height_q <= htab[m_d];
      total_q  <= ttab[m_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wr_idx_q <= block_index_i;
      wr_bit_q <= bit_value_i;
    end
  end

  tbmr_div #(
    .NUM_W (COORD_W),
    .DEN_W (WW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.capture),
    .num_i   (pixel_x_i),
    .den_i   (width_q),
    .quo_o   (col),
    .done_o  (done_x)
  );

  tbmr_div #(
    .NUM_W (COORD_W),
    .DEN_W (HW)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.capture),
    .num_i   (pixel_y_i),
    .den_i   (height_q),
    .quo_o   (row),
    .done_o  (done_y)
  );

  // Row r starts at r*m - r(r-1)/2, which equals r*(2m+1-r)/2.
  always_comb begin
    row_ext = SW'(row);
    sum     = SW'(col) + SW'(row);
    m_ext   = SW'(m_q);
    hit_d   = (width_q != '0) && (height_q != '0) && (row_ext < m_ext) && (sum < m_ext);
    r_s     = MW'(row);
    two_m1  = {m_q, 1'b1};
    prod    = PW'(r_s) * PW'(two_m1 - (MW + 1)'(r_s));
    idx_d   = AW'(prod >> 1) + AW'(col);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index_en) begin
      idx_q <= idx_d;
      hit_q <= hit_d;
    end
  end

  assign wr_ok  = CW'(wr_idx_q) < CW'(total_q);
  assign mem_we = cmd_i.clr_step | (cmd_i.wr_commit & wr_ok);
  assign mem_wa = cmd_i.clr_step ? clr_q : AW'(wr_idx_q);
  assign mem_wd = cmd_i.clr_step ? 1'b0 : wr_bit_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bits_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      bit_q <= hit_q & bits_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_q <= bit_q;
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(StoreDepth - 1));
  assign sts_o.div_done = done_x & done_y;
  assign pixel_on_o     = pixel_q;

endmodule

>>> design/tbmr_ctrl.sv
module tbmr_ctrl import tbmr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WRITE = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_INDEX = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_SEND  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = (in_op_i == OP_QUERY) ? ST_DIV : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        cmd_o.index_en = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/tbmr_checker.sv
module tbmr_checker import tbmr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_op_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic pixel_on_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // Queries accepted whose result has not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'((in_xfer && in_op_i == OP_QUERY) ? 1 : 0)
                       - 2'(out_xfer ? 1 : 0);
    end
  end

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two queries in flight");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result offered without an outstanding query");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op_i == OP_WRITE) |=> !$rose(out_valid_i))
    else $error("a write produced a result");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready straight after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(pixel_on_i)))
    else $error("stalled result changed or dropped");

endmodule

bind triangular_block_mask_raster_top tbmr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_op_i     (req_i.operation),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .pixel_on_i  (rsp_o.pixel_on)
);
